>>> design/dtqdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtqdm_pkg
// Shared constants, register indexes and the controller command bundle for
// the drop-tail queue delay monitor.
// ----------------------------------------------------------------------------
package dtqdm_pkg;

  localparam int DTQDM_FIFO_DEPTH = 64;
  localparam int DTQDM_STAMP_BITS = 32;

  localparam int CAP_W      = 7;
  localparam int SVC_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OCC_W      = 7;
  localparam int CNT_W32    = 32;
  localparam int ACC_W      = 48;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;
  localparam logic [SVC_W-1:0] SERVICE_RST  = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMITED  = 2'd0,
    REG_CAPACITY = 2'd1,
    REG_SERVICE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;     // latch request, advance tick
    logic arrival;  // run admission and push
    logic rd_head;  // read head stamp
    logic depart;   // run departure
    logic accum;    // update running sums
  } dtqdm_cmd_t;

endpackage

>>> design/drop_tail_queue_delay_monitor_unit.sv
`timescale 1ns / 1ps
// The result strobe is registered from the accumulate step of the four-step sequencer
// around the registered read of the stamp RAM (admit/push, head read, depart,
// accumulate); busy stays high and no new request is taken until it returns to idle.
// out_strobe is high for one cycle only; the receiver cannot stall.
// Synchronous reset clears the tick, pointers, counters and sums and loads the
// register defaults; stamp RAM contents are not cleared.
// ----------------------------------------------------------------------------
// drop_tail_queue_delay_monitor_unit
// Tick-driven drop-tail queue monitor with deterministic service, reporting
// per-tick occupancy, drops, departures, sojourn and saturating totals.
// ----------------------------------------------------------------------------
module drop_tail_queue_delay_monitor_unit
  import dtqdm_pkg::*;
#(
  parameter int FIFO_DEPTH = DTQDM_FIFO_DEPTH,
  parameter int STAMP_BITS = DTQDM_STAMP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_arrive,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_strobe,
  output logic [OCC_W-1:0]      out_occupancy,
  output logic                  out_departed,
  output logic [CNT_W32-1:0]    out_sojourn,
  output logic                  out_dropped,
  output logic                  out_overflow,
  output logic                  out_idle,
  output logic [CNT_W32-1:0]    out_sent_total,
  output logic [CNT_W32-1:0]    out_received_total,
  output logic [CNT_W32-1:0]    out_idle_total,
  output logic [ACC_W-1:0]      out_sojourn_sum,
  output logic [ACC_W-1:0]      out_occupancy_sum
);

  dtqdm_cmd_t cmd;

  dtqdm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (out_strobe),
    .cmd    (cmd)
  );

  dtqdm_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_arrive          (in_arrive),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_occupancy      (out_occupancy),
    .out_departed       (out_departed),
    .out_sojourn        (out_sojourn),
    .out_dropped        (out_dropped),
    .out_overflow       (out_overflow),
    .out_idle           (out_idle),
    .out_sent_total     (out_sent_total),
    .out_received_total (out_received_total),
    .out_idle_total     (out_idle_total),
    .out_sojourn_sum    (out_sojourn_sum),
    .out_occupancy_sum  (out_occupancy_sum)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_overflow_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_overflow) |-> out_dropped)
    else $error("overflow without drop");

  a_idle_depart: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_idle && out_departed))
    else $error("departure on an idle tick");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_occupancy) <= 32'(FIFO_DEPTH)))
    else $error("occupancy above FIFO depth");
`endif

endmodule

>>> design/dtqdm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtqdm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtqdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/dtqdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtqdm_ctrl
// Sequencer: accept a request, then step the datapath through admission,
// head read, departure and accumulation, and strobe the result.
// ----------------------------------------------------------------------------
module dtqdm_ctrl
  import dtqdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       strobe,
  output dtqdm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR,
    S_RD,
    S_DEP,
    S_SUM
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_ARR;
        end
      end
      S_ARR: begin
        cmd.arrival = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_DEP;
      end
      S_DEP: begin
        cmd.depart = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.accum  = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy   = busy_r;
  assign strobe = strobe_r;

endmodule

>>> design/dtqdm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtqdm_dp
// Datapath: configuration registers, tick counter, stamp FIFO with its
// pointers, departure timer and saturating counters and sums.
// ----------------------------------------------------------------------------
module dtqdm_dp
  import dtqdm_pkg::*;
#(
  parameter int FIFO_DEPTH = DTQDM_FIFO_DEPTH,
  parameter int STAMP_BITS = DTQDM_STAMP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtqdm_cmd_t            cmd,
  input  logic                  in_arrive,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [OCC_W-1:0]      out_occupancy,
  output logic                  out_departed,
  output logic [CNT_W32-1:0]    out_sojourn,
  output logic                  out_dropped,
  output logic                  out_overflow,
  output logic                  out_idle,
  output logic [CNT_W32-1:0]    out_sent_total,
  output logic [CNT_W32-1:0]    out_received_total,
  output logic [CNT_W32-1:0]    out_idle_total,
  output logic [ACC_W-1:0]      out_sojourn_sum,
  output logic [ACC_W-1:0]      out_occupancy_sum
);

  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int OCCX_W  = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  localparam int SOJX_W  = (STAMP_BITS > CNT_W32) ? STAMP_BITS : CNT_W32;
  localparam int SUM_W   = ((STAMP_BITS > ACC_W) ? STAMP_BITS : ACC_W) + 1;

  localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [SUM_W-1:0]   ACC_LIMIT = SUM_W'({ACC_W{1'b1}});

  logic                  limited_r, limited_nxt;
  logic [CAP_W-1:0]      capacity_r, capacity_nxt;
  logic [SVC_W-1:0]      service_r, service_nxt;
  logic                  arrive_r, arrive_nxt;
  logic [STAMP_BITS-1:0] tick_r, tick_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [STAMP_BITS-1:0] next_dep_r, next_dep_nxt;
  logic [CNT_W32-1:0]    sent_r, sent_nxt;
  logic [CNT_W32-1:0]    recv_r, recv_nxt;
  logic [CNT_W32-1:0]    idle_cnt_r, idle_cnt_nxt;
  logic [ACC_W-1:0]      soj_acc_r, soj_acc_nxt;
  logic [ACC_W-1:0]      occ_acc_r, occ_acc_nxt;
  logic [STAMP_BITS-1:0] sojourn_r, sojourn_nxt;
  logic                  departed_r, departed_nxt;
  logic                  dropped_r, dropped_nxt;
  logic                  overflow_r, overflow_nxt;
  logic                  idle_r, idle_nxt;

  logic                  ram_we;
  logic [STAMP_BITS-1:0] head_stamp;
  logic [SUM_W-1:0]      soj_sum;
  logic [SUM_W-1:0]      occ_sum;
  logic [OCCX_W-1:0]     occ_ext;
  logic [SOJX_W-1:0]     soj_ext;

  dtqdm_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (tick_r),
    .re    (cmd.rd_head),
    .raddr (head_r),
    .rdata (head_stamp)
  );

  assign soj_sum = SUM_W'(soj_acc_r) + SUM_W'(sojourn_r);
  assign occ_sum = SUM_W'(occ_acc_r) + SUM_W'(fill_r);

  always_comb begin
    limited_nxt  = limited_r;
    capacity_nxt = capacity_r;
    service_nxt  = service_r;
    arrive_nxt   = arrive_r;
    tick_nxt     = tick_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    next_dep_nxt = next_dep_r;
    sent_nxt     = sent_r;
    recv_nxt     = recv_r;
    idle_cnt_nxt = idle_cnt_r;
    soj_acc_nxt  = soj_acc_r;
    occ_acc_nxt  = occ_acc_r;
    sojourn_nxt  = sojourn_r;
    departed_nxt = departed_r;
    dropped_nxt  = dropped_r;
    overflow_nxt = overflow_r;
    idle_nxt     = idle_r;
    ram_we       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIMITED:  limited_nxt  = cfg_wdata[0];
        REG_CAPACITY: capacity_nxt = cfg_wdata[CAP_W-1:0];
        REG_SERVICE:  service_nxt  = cfg_wdata[SVC_W-1:0];
        default: begin
        end
      endcase
    end

    if (cmd.load) begin
      arrive_nxt = in_arrive;
      tick_nxt   = tick_r + 1'b1;
    end

    if (cmd.arrival) begin
      dropped_nxt  = 1'b0;
      overflow_nxt = 1'b0;
      if (arrive_r) begin
        if (sent_r != '1) begin
          sent_nxt = sent_r + 1'b1;
        end
        if (limited_r && (CMP_W'(fill_r) >= CMP_W'(capacity_r))) begin
          dropped_nxt = 1'b1;
        end else if (fill_r == FULL_CNT) begin
          dropped_nxt  = 1'b1;
          overflow_nxt = 1'b1;
        end else begin
          ram_we   = 1'b1;
          tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
    end

    if (cmd.depart) begin
      idle_nxt     = 1'b0;
      departed_nxt = 1'b0;
      sojourn_nxt  = '0;
      if (fill_r == '0) begin
        idle_nxt     = 1'b1;
        next_dep_nxt = tick_r + STAMP_BITS'(service_r);
        if (idle_cnt_r != '1) begin
          idle_cnt_nxt = idle_cnt_r + 1'b1;
        end
      end else if (tick_r >= next_dep_r) begin
        departed_nxt = 1'b1;
        sojourn_nxt  = tick_r - head_stamp;
        next_dep_nxt = tick_r + STAMP_BITS'(service_r);
        head_nxt     = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
        fill_nxt     = fill_r - 1'b1;
        if (recv_r != '1) begin
          recv_nxt = recv_r + 1'b1;
        end
      end
    end

    if (cmd.accum) begin
      soj_acc_nxt = (soj_sum > ACC_LIMIT) ? ACC_LIMIT[ACC_W-1:0] : soj_sum[ACC_W-1:0];
      occ_acc_nxt = (occ_sum > ACC_LIMIT) ? ACC_LIMIT[ACC_W-1:0] : occ_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limited_r  <= 1'b0;
      capacity_r <= CAPACITY_RST;
      service_r  <= SERVICE_RST;
      arrive_r   <= 1'b0;
      tick_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      fill_r     <= '0;
      next_dep_r <= '0;
      sent_r     <= '0;
      recv_r     <= '0;
      idle_cnt_r <= '0;
      soj_acc_r  <= '0;
      occ_acc_r  <= '0;
      departed_r <= 1'b0;
      dropped_r  <= 1'b0;
      overflow_r <= 1'b0;
      idle_r     <= 1'b0;
    end else begin
      limited_r  <= limited_nxt;
      capacity_r <= capacity_nxt;
      service_r  <= service_nxt;
      arrive_r   <= arrive_nxt;
      tick_r     <= tick_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      fill_r     <= fill_nxt;
      next_dep_r <= next_dep_nxt;
      sent_r     <= sent_nxt;
      recv_r     <= recv_nxt;
      idle_cnt_r <= idle_cnt_nxt;
      soj_acc_r  <= soj_acc_nxt;
      occ_acc_r  <= occ_acc_nxt;
      departed_r <= departed_nxt;
      dropped_r  <= dropped_nxt;
      overflow_r <= overflow_nxt;
      idle_r     <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sojourn_r <= sojourn_nxt;
  end

  assign occ_ext = OCCX_W'(fill_r);
  assign soj_ext = SOJX_W'(sojourn_r);

  assign out_occupancy      = occ_ext[OCC_W-1:0];
  assign out_departed       = departed_r;
  assign out_sojourn        = soj_ext[CNT_W32-1:0];
  assign out_dropped        = dropped_r;
  assign out_overflow       = overflow_r;
  assign out_idle           = idle_r;
  assign out_sent_total     = sent_r;
  assign out_received_total = recv_r;
  assign out_idle_total     = idle_cnt_r;
  assign out_sojourn_sum    = soj_acc_r;
  assign out_occupancy_sum  = occ_acc_r;

endmodule

>>> sim/queue_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_tick_checker
// Watches the request, register and result ports of the drop-tail queue
// monitor. It keeps its own copy of the queue state and predicts every
// per-tick report, then compares the reports field by field in order.
// ----------------------------------------------------------------------------
module queue_tick_checker
  import dtqdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_arrive,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_strobe,
  input  logic [OCC_W-1:0]      out_occupancy,
  input  logic                  out_departed,
  input  logic [CNT_W32-1:0]    out_sojourn,
  input  logic                  out_dropped,
  input  logic                  out_overflow,
  input  logic                  out_idle,
  input  logic [CNT_W32-1:0]    out_sent_total,
  input  logic [CNT_W32-1:0]    out_received_total,
  input  logic [CNT_W32-1:0]    out_idle_total,
  input  logic [ACC_W-1:0]      out_sojourn_sum,
  input  logic [ACC_W-1:0]      out_occupancy_sum,
  output int                    fail_count,
  output int                    pending,
  output int                    ticks_checked,
  output int                    departures,
  output int                    capacity_drops,
  output int                    full_drops
);

  localparam int DEPTH = DTQDM_FIFO_DEPTH;

  typedef struct packed {
    logic [OCC_W-1:0]   occupancy;
    logic               departed;
    logic [CNT_W32-1:0] sojourn;
    logic               dropped;
    logic               overflow;
    logic               idle;
    logic [CNT_W32-1:0] sent_total;
    logic [CNT_W32-1:0] received_total;
    logic [CNT_W32-1:0] idle_total;
    logic [ACC_W-1:0]   sojourn_sum;
    logic [ACC_W-1:0]   occupancy_sum;
  } tick_report_t;

  logic                  lim_mode;
  logic [CAP_W-1:0]      cap_lim;
  logic [SVC_W-1:0]      svc_ticks;
  logic [31:0]           tick_now;
  logic [31:0]           stamps [DEPTH];
  int                    head_idx;
  int                    tail_idx;
  logic [OCC_W-1:0]      fill;
  logic [31:0]           next_due;
  logic [CNT_W32-1:0]    sent_cnt;
  logic [CNT_W32-1:0]    recv_cnt;
  logic [CNT_W32-1:0]    idle_cnt;
  logic [ACC_W-1:0]      sojourn_acc;
  logic [ACC_W-1:0]      occ_acc;
  tick_report_t          due_reports [$];
  int                    mismatches;
  int                    n_checked;
  int                    n_departed;
  int                    n_cap_drop;
  int                    n_full_drop;

  function automatic logic [CNT_W32-1:0] bump32(input logic [CNT_W32-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [ACC_W-1:0] add48(input logic [ACC_W-1:0] acc,
                                             input logic [ACC_W-1:0] x);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + {1'b0, x};
    return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
  endfunction

  function automatic tick_report_t predict_tick(input logic arrive);
    tick_report_t r;
    r = '0;
    tick_now = tick_now + 1;
    if (arrive) begin
      sent_cnt = bump32(sent_cnt);
      if (lim_mode && fill >= cap_lim) begin
        r.dropped = 1'b1;
      end else if (fill >= DEPTH) begin
        r.dropped  = 1'b1;
        r.overflow = 1'b1;
      end else begin
        stamps[tail_idx] = tick_now;
        tail_idx = (tail_idx + 1) % DEPTH;
        fill = fill + 1'b1;
      end
    end
    if (fill == 0) begin
      r.idle   = 1'b1;
      idle_cnt = bump32(idle_cnt);
      next_due = tick_now + {16'b0, svc_ticks};
    end else if (tick_now >= next_due) begin
      r.departed  = 1'b1;
      r.sojourn   = tick_now - stamps[head_idx];
      recv_cnt    = bump32(recv_cnt);
      sojourn_acc = add48(sojourn_acc, {16'b0, r.sojourn});
      next_due    = tick_now + {16'b0, svc_ticks};
      head_idx    = (head_idx + 1) % DEPTH;
      fill        = fill - 1'b1;
    end
    occ_acc = add48(occ_acc, {41'b0, fill});
    r.occupancy      = fill;
    r.sent_total     = sent_cnt;
    r.received_total = recv_cnt;
    r.idle_total     = idle_cnt;
    r.sojourn_sum    = sojourn_acc;
    r.occupancy_sum  = occ_acc;
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] report %0d field %s: expected %0h, got %0h",
                 $realtime, n_checked, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    tick_report_t want;
    if (!rst_n) begin
      lim_mode    = 1'b0;
      cap_lim     = CAPACITY_RST;
      svc_ticks   = SERVICE_RST;
      tick_now    = '0;
      head_idx    = 0;
      tail_idx    = 0;
      fill        = '0;
      next_due    = '0;
      sent_cnt    = '0;
      recv_cnt    = '0;
      idle_cnt    = '0;
      sojourn_acc = '0;
      occ_acc     = '0;
      due_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LIMITED:  lim_mode  = cfg_wdata[0];
          REG_CAPACITY: cap_lim   = cfg_wdata[CAP_W-1:0];
          REG_SERVICE:  svc_ticks = cfg_wdata[SVC_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = predict_tick(in_arrive);
        due_reports.push_back(want);
        if (want.departed) n_departed++;
        if (want.dropped && !want.overflow) n_cap_drop++;
        if (want.overflow) n_full_drop++;
      end
      if (out_strobe) begin
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] report with no request outstanding", $realtime);
        end else begin
          want = due_reports.pop_front();
          compare_field("occupancy", ACC_W'(want.occupancy), ACC_W'(out_occupancy));
          compare_field("departed", ACC_W'(want.departed), ACC_W'(out_departed));
          compare_field("sojourn", ACC_W'(want.sojourn), ACC_W'(out_sojourn));
          compare_field("dropped", ACC_W'(want.dropped), ACC_W'(out_dropped));
          compare_field("overflow", ACC_W'(want.overflow), ACC_W'(out_overflow));
          compare_field("idle", ACC_W'(want.idle), ACC_W'(out_idle));
          compare_field("sent_total", ACC_W'(want.sent_total),
                        ACC_W'(out_sent_total));
          compare_field("received_total", ACC_W'(want.received_total),
                        ACC_W'(out_received_total));
          compare_field("idle_total", ACC_W'(want.idle_total),
                        ACC_W'(out_idle_total));
          compare_field("sojourn_sum", want.sojourn_sum, out_sojourn_sum);
          compare_field("occupancy_sum", want.occupancy_sum, out_occupancy_sum);
          n_checked++;
        end
      end
    end
    pending        <= due_reports.size();
    fail_count     <= mismatches;
    ticks_checked  <= n_checked;
    departures     <= n_departed;
    capacity_drops <= n_cap_drop;
    full_drops     <= n_full_drop;
  end

endmodule

>>> sim/drop_tail_queue_delay_monitor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drop_tail_queue_delay_monitor_unit_test
// Drives tick requests and register writes into the drop-tail queue monitor
// through a series of service and capacity settings, with random request
// gaps, and reports the verdict from the attached report checker.
// ----------------------------------------------------------------------------
module drop_tail_queue_delay_monitor_unit_test;
  import dtqdm_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_arrive = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  out_strobe;
  logic [OCC_W-1:0]      out_occupancy;
  logic                  out_departed;
  logic [CNT_W32-1:0]    out_sojourn;
  logic                  out_dropped;
  logic                  out_overflow;
  logic                  out_idle;
  logic [CNT_W32-1:0]    out_sent_total;
  logic [CNT_W32-1:0]    out_received_total;
  logic [CNT_W32-1:0]    out_idle_total;
  logic [ACC_W-1:0]      out_sojourn_sum;
  logic [ACC_W-1:0]      out_occupancy_sum;

  int fail_count;
  int pending;
  int ticks_checked;
  int departures;
  int capacity_drops;
  int full_drops;
  int cycles = 0;
  int setups = 1;

  drop_tail_queue_delay_monitor_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_arrive          (in_arrive),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_strobe         (out_strobe),
    .out_occupancy      (out_occupancy),
    .out_departed       (out_departed),
    .out_sojourn        (out_sojourn),
    .out_dropped        (out_dropped),
    .out_overflow       (out_overflow),
    .out_idle           (out_idle),
    .out_sent_total     (out_sent_total),
    .out_received_total (out_received_total),
    .out_idle_total     (out_idle_total),
    .out_sojourn_sum    (out_sojourn_sum),
    .out_occupancy_sum  (out_occupancy_sum)
  );

  queue_tick_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_arrive          (in_arrive),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_strobe         (out_strobe),
    .out_occupancy      (out_occupancy),
    .out_departed       (out_departed),
    .out_sojourn        (out_sojourn),
    .out_dropped        (out_dropped),
    .out_overflow       (out_overflow),
    .out_idle           (out_idle),
    .out_sent_total     (out_sent_total),
    .out_received_total (out_received_total),
    .out_idle_total     (out_idle_total),
    .out_sojourn_sum    (out_sojourn_sum),
    .out_occupancy_sum  (out_occupancy_sum),
    .fail_count         (fail_count),
    .pending            (pending),
    .ticks_checked      (ticks_checked),
    .departures         (departures),
    .capacity_drops     (capacity_drops),
    .full_drops         (full_drops)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // hold start until the request is taken; idle at random beforehand
  task automatic send_tick(input logic arrive, input bit gaps_on);
    if (gaps_on && $urandom_range(99) < 30) begin
      start     <= 1'b0;
      in_arrive <= 1'($urandom_range(1));
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start     <= 1'b1;
    in_arrive <= arrive;
    do @(posedge clk); while (busy);
  endtask

  // drop start, wait for every report, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setup(input logic lim, input int cap, input int svc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LIMITED;
    cfg_wdata <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_index <= REG_CAPACITY;
    cfg_wdata <= CFG_DATA_W'(cap);
    @(posedge clk);
    cfg_index <= REG_SERVICE;
    cfg_wdata <= CFG_DATA_W'(svc);
    @(posedge clk);
    cfg_we <= 1'b0;
    setups++;
  endtask

  task automatic random_phase(input logic lim, input int cap, input int svc,
                              input int count, input int arrive_pct,
                              input bit gaps_on);
    settle();
    apply_setup(lim, cap, svc);
    repeat (count) send_tick($urandom_range(99) < arrive_pct, gaps_on);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);

    settle();
    apply_setup(1'b0, 64, 0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);

    settle();
    apply_setup(1'b1, 0, 2);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);

    settle();
    apply_setup(1'b1, 2, 5);
    repeat (4) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);

    random_phase(1'b0, 64, 1, 60, 50, 1'b1);
    random_phase(1'b1, 5, 3, 60, 60, 1'b1);
    random_phase(1'b0, 100, 3, 130, 95, 1'b0);
    random_phase(1'b1, 127, 4, 50, 90, 1'b1);
    random_phase(1'b1, 64, 7, 50, 80, 1'b1);
    random_phase(1'b0, 0, 0, 60, 15, 1'b1);
    random_phase(1'b1, 1, 1, 60, 70, 1'b1);
    random_phase(1'b0, 64, 65535, 80, 90, 1'b1);

    settle();
    $display("checked %0d tick reports over %0d register settings", ticks_checked,
             setups);
    $display("departures %0d, capacity drops %0d, full-queue drops %0d",
             departures, capacity_drops, full_drops);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
